FILE: rtl/core/iamd_pkg.sv
// iamd_pkg: shared constants and types for the integer execute unit
// no dependencies
package iamd_pkg;

    localparam int NUM_REGS = 32;
    localparam int REG_AW = 5;
    localparam int XLEN = 32;

    localparam logic [6:0] OP_REG = 7'b0110011;
    localparam logic [6:0] OP_IMM = 7'b0010011;
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT = 7'h20;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SLT = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SR = 3'd5;
    localparam logic [2:0] F3_OR = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

    // funct3 codes of the multiply/divide group
    localparam logic [2:0] F3_MUL = 3'd0;
    localparam logic [2:0] F3_MULH = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU = 3'd3;
    localparam logic [2:0] F3_DIV = 3'd4;
    localparam logic [2:0] F3_DIVU = 3'd5;
    localparam logic [2:0] F3_REM = 3'd6;
    localparam logic [2:0] F3_REMU = 3'd7;

    // operation class chosen by the decoder
    typedef enum logic [1:0] {
        CLS_ALU,
        CLS_MUL,
        CLS_DIV,
        CLS_ILL
    } op_class_t;

endpackage

FILE: rtl/core/integer_alu_with_muldiv.sv
// integer_alu_with_muldiv: rv32im register/immediate execute unit with own register file
// depends on iamd_pkg
//
//  channel | ports                                         | dir | role
//  input   | s_valid, s_ready, s_instruction               | in  | instruction words
//  result  | m_valid, m_ready, m_dest_index, m_write_value,| out | one result per instruction
//          | m_wrote, m_illegal                            |     |
//
// reset clears the register file one entry a cycle, s_ready low meanwhile
// alu ops: read, alu, write back, then the result is registered; s_ready stays low until write back
// mul/div/rem: read, setup, 32 shift-add or restoring steps in the shared adder, a select
// step, then write back; s_ready stays low until write back, so one instruction is in the unit
// the write back cycle waits while the output register still holds an unaccepted result,
// so a stalled m_ready stalls the next instruction at write back and then the input
module integer_alu_with_muldiv (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instruction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_dest_index,
    output logic [31:0] m_write_value,
    output logic        m_wrote,
    output logic        m_illegal
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_ITER,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic [iamd_pkg::REG_AW-1:0] clr_reg;

    // register file, read and written in clocked blocks
    logic [31:0] rf_mem [iamd_pkg::NUM_REGS];
    logic [31:0] rd_a_reg, rd_b_reg;

    logic [31:0] ins_reg;
    logic [31:0] a_reg, b_reg;          // operands
    logic [31:0] acc_reg;               // mul high / div remainder
    logic [31:0] q_reg;                 // mul low (multiplier) / div quotient
    logic [5:0]  cnt_reg;
    logic        neg_res_reg;
    logic [31:0] res_reg;
    logic        ill_reg;

    logic        out_v_reg;
    logic [4:0]  out_rd_reg;
    logic [31:0] out_val_reg;
    logic        out_wr_reg;
    logic        out_ill_reg;

    logic [6:0] opc, f7;
    logic [2:0] f3;
    logic [4:0] rdi, rs1, rs2;
    assign opc = ins_reg[6:0];
    assign rdi = ins_reg[11:7];
    assign f3  = ins_reg[14:12];
    assign rs1 = ins_reg[19:15];
    assign rs2 = ins_reg[24:20];
    assign f7  = ins_reg[31:25];

    // decode
    iamd_pkg::op_class_t cls;
    always_comb begin
        cls = iamd_pkg::CLS_ILL;
        if (opc == iamd_pkg::OP_REG) begin
            if (f7 == iamd_pkg::F7_BASE) cls = iamd_pkg::CLS_ALU;
            else if (f7 == iamd_pkg::F7_MULDIV) cls = f3[2] ? iamd_pkg::CLS_DIV : iamd_pkg::CLS_MUL;
            else if (f7 == iamd_pkg::F7_ALT && (f3 == iamd_pkg::F3_ADD || f3 == iamd_pkg::F3_SR))
                cls = iamd_pkg::CLS_ALU;
        end else if (opc == iamd_pkg::OP_IMM) begin
            if (f3 == iamd_pkg::F3_SLL) begin
                if (f7 == iamd_pkg::F7_BASE) cls = iamd_pkg::CLS_ALU;
            end else if (f3 == iamd_pkg::F3_SR) begin
                if (f7 == iamd_pkg::F7_BASE || f7 == iamd_pkg::F7_ALT) cls = iamd_pkg::CLS_ALU;
            end else begin
                cls = iamd_pkg::CLS_ALU;
            end
        end
    end

    // combinational alu on the read operands
    logic [31:0] opa, opb, alu_res;
    logic        alt;
    always_comb begin
        opa = rd_a_reg;
        opb = (opc == iamd_pkg::OP_REG) ? rd_b_reg : {{20{ins_reg[31]}}, ins_reg[31:20]};
        alt = f7[5];
        case (f3)
            iamd_pkg::F3_ADD:  alu_res = (alt && opc == iamd_pkg::OP_REG) ? opa - opb : opa + opb;
            iamd_pkg::F3_SLL:  alu_res = opa << opb[4:0];
            iamd_pkg::F3_SLT:  alu_res = {31'd0, $signed(opa) < $signed(opb)};
            iamd_pkg::F3_SLTU: alu_res = {31'd0, opa < opb};
            iamd_pkg::F3_XOR:  alu_res = opa ^ opb;
            iamd_pkg::F3_SR:   alu_res = alt ? 32'($signed(opa) >>> opb[4:0]) : opa >> opb[4:0];
            iamd_pkg::F3_OR:   alu_res = opa | opb;
            default:           alu_res = opa & opb;
        endcase
    end

    // signedness of operands for mul/div
    logic sa, sb;
    always_comb begin
        case (f3)
            iamd_pkg::F3_MULH:   begin sa = 1'b1; sb = 1'b1; end
            iamd_pkg::F3_MULHSU: begin sa = 1'b1; sb = 1'b0; end
            iamd_pkg::F3_DIV:    begin sa = 1'b1; sb = 1'b1; end
            iamd_pkg::F3_REM:    begin sa = 1'b1; sb = 1'b1; end
            default:             begin sa = 1'b0; sb = 1'b0; end
        endcase
    end

    logic na, nb;
    logic [31:0] mag_a, mag_b;
    assign na = sa & rd_a_reg[31];
    assign nb = sb & rd_b_reg[31];
    assign mag_a = na ? 32'(0 - rd_a_reg) : rd_a_reg;
    assign mag_b = nb ? 32'(0 - rd_b_reg) : rd_b_reg;

    // shared adder: mul adds multiplicand, div subtracts divisor
    logic        is_div;
    logic [32:0] add_res;
    logic [32:0] rem_sh;
    assign is_div = f3[2];
    assign rem_sh = {acc_reg, q_reg[31]};
    always_comb begin
        if (is_div) add_res = rem_sh - {1'b0, b_reg};
        else        add_res = {1'b0, acc_reg} + {1'b0, (q_reg[0] ? a_reg : 32'd0)};
    end

    // 64-bit unsigned product held as {acc_reg, q_reg}
    logic [63:0] prod, prod_s;
    assign prod   = {acc_reg, q_reg};
    assign prod_s = neg_res_reg ? 64'(0 - prod) : prod;

    logic [31:0] div_q, div_r;
    assign div_q = neg_res_reg ? 32'(0 - q_reg) : q_reg;
    assign div_r = neg_res_reg ? 32'(0 - acc_reg) : acc_reg;

    logic out_free;
    assign out_free = !out_v_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // first finish cycle of mul/div picks the signed result, write back follows once the output is free
    logic pick, out_load;
    assign pick = (state_reg == ST_FINISH) && (cnt_reg == 6'd0)
                  && (cls == iamd_pkg::CLS_MUL || cls == iamd_pkg::CLS_DIV);
    assign out_load = (state_reg == ST_FINISH) && !pick && out_free;

    logic we;
    assign we = out_load && !ill_reg
                && rdi != 5'd0 && int'(rdi) < iamd_pkg::NUM_REGS;

    // register file port, with clearing sweep after reset
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            rf_mem[clr_reg] <= 32'd0;
        end else if (we) begin
            rf_mem[rdi] <= res_reg;
        end
        rd_a_reg <= (rs1 == 5'd0 || int'(rs1) >= iamd_pkg::NUM_REGS) ? 32'd0 : rf_mem[rs1];
        rd_b_reg <= (rs2 == 5'd0 || int'(rs2) >= iamd_pkg::NUM_REGS) ? 32'd0 : rf_mem[rs2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            out_v_reg <= 1'b0;
        end else begin
            if (out_load) out_v_reg <= 1'b1;
            else if (m_valid && m_ready) out_v_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == iamd_pkg::REG_AW'(iamd_pkg::NUM_REGS - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        ins_reg   <= s_instruction;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    // register file read data lands here
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    ill_reg <= (cls == iamd_pkg::CLS_ILL);
                    cnt_reg <= '0;
                    if (cls == iamd_pkg::CLS_MUL) begin
                        a_reg       <= mag_a;
                        q_reg       <= mag_b;
                        acc_reg     <= '0;
                        neg_res_reg <= na ^ nb;
                        state_reg   <= ST_ITER;
                    end else if (cls == iamd_pkg::CLS_DIV) begin
                        b_reg   <= mag_b;
                        q_reg   <= mag_a;
                        acc_reg <= '0;
                        // quotient sign, or dividend sign for remainder
                        neg_res_reg <= f3[1] ? na : (na ^ nb) & (rd_b_reg != 32'd0);
                        state_reg   <= ST_ITER;
                    end else begin
                        res_reg   <= (cls == iamd_pkg::CLS_ALU) ? alu_res : 32'd0;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_ITER: begin
                    if (is_div) begin
                        if (!add_res[32]) begin
                            acc_reg <= add_res[31:0];
                            q_reg   <= {q_reg[30:0], 1'b1};
                        end else begin
                            acc_reg <= rem_sh[31:0];
                            q_reg   <= {q_reg[30:0], 1'b0};
                        end
                    end else begin
                        {acc_reg, q_reg} <= {add_res, q_reg[31:1]};
                    end
                    if (cnt_reg == 6'd31) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (pick) begin
                        // first finish cycle after the loop: pick the result
                        cnt_reg <= 6'd1;
                        if (is_div) res_reg <= f3[1] ? div_r : div_q;
                        else if (f3 == iamd_pkg::F3_MUL) res_reg <= prod_s[31:0];
                        else res_reg <= prod_s[63:32];
                    end else if (out_free) begin
                        out_rd_reg  <= rdi;
                        out_val_reg <= res_reg;
                        out_wr_reg  <= we;
                        out_ill_reg <= ill_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = out_v_reg;
    assign m_dest_index  = out_rd_reg;
    assign m_write_value = out_val_reg;
    assign m_wrote       = out_wr_reg;
    assign m_illegal     = out_ill_reg;

endmodule

FILE: test/testbench.sv
// testbench for integer_alu_with_muldiv: directed and random rv32 reg/imm instructions
// depends on iamd_pkg and the integer_alu_with_muldiv rtl; predicts results with its own model
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // one predicted result
    typedef struct packed {
        logic [4:0]  rd;
        logic [31:0] value;
        logic        wrote;
        logic        illegal;
    } exec_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_instruction;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_dest_index;
    logic [31:0] m_write_value;
    logic        m_wrote;
    logic        m_illegal;

    integer_alu_with_muldiv dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_instruction(s_instruction),
        .m_valid(m_valid), .m_ready(m_ready), .m_dest_index(m_dest_index),
        .m_write_value(m_write_value), .m_wrote(m_wrote), .m_illegal(m_illegal)
    );

    // shadow register file and the queues around it
    logic [31:0]  shadow_regs [0:31];
    logic [31:0]  pending_instr [$];
    exec_result_t staged [$];
    exec_result_t expected_results [$];
    int           errors = 0;
    int           n_sent = 0;
    int           n_checked = 0;
    int           n_illegal = 0;
    int           send_idle_pct = 19;
    int           recv_stall_pct = 50;
    bit           hold_sender = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] read_shadow(logic [4:0] idx);
        if (idx == 0 || idx >= iamd_pkg::NUM_REGS) return '0;
        return shadow_regs[idx];
    endfunction

    // execute one instruction against the shadow state
    function automatic exec_result_t execute(logic [31:0] ins);
        exec_result_t r;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  sh;
        logic [31:0] a, b, imm, q;
        logic signed [63:0] sp;
        logic [63:0] up;
        logic        bad;
        opc = ins[6:0];
        f3  = ins[14:12];
        f7  = ins[31:25];
        sh  = ins[24:20];
        imm = {{20{ins[31]}}, ins[31:20]};
        a   = read_shadow(ins[19:15]);
        b   = read_shadow(ins[24:20]);
        bad = 0;
        r.value = '0;
        if (opc == iamd_pkg::OP_REG) begin
            if (f7 == iamd_pkg::F7_BASE || (f7 == iamd_pkg::F7_ALT &&
                (f3 == iamd_pkg::F3_ADD || f3 == iamd_pkg::F3_SR))) begin
                case (f3)
                    iamd_pkg::F3_ADD:  r.value = (f7 == iamd_pkg::F7_ALT) ? a - b : a + b;
                    iamd_pkg::F3_SLL:  r.value = a << b[4:0];
                    iamd_pkg::F3_SLT:  r.value = {31'b0, $signed(a) < $signed(b)};
                    iamd_pkg::F3_SLTU: r.value = {31'b0, a < b};
                    iamd_pkg::F3_XOR:  r.value = a ^ b;
                    iamd_pkg::F3_SR:   r.value = (f7 == iamd_pkg::F7_ALT)
                                                 ? $unsigned($signed(a) >>> b[4:0])
                                                 : a >> b[4:0];
                    iamd_pkg::F3_OR:   r.value = a | b;
                    default:           r.value = a & b;
                endcase
            end else if (f7 == iamd_pkg::F7_MULDIV) begin
                case (f3)
                    iamd_pkg::F3_MUL: r.value = a * b;
                    iamd_pkg::F3_MULH: begin
                        sp = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                        r.value = sp[63:32];
                    end
                    iamd_pkg::F3_MULHSU: begin
                        sp = $signed({{32{a[31]}}, a}) * $signed({32'b0, b});
                        r.value = sp[63:32];
                    end
                    iamd_pkg::F3_MULHU: begin
                        up = {32'b0, a} * {32'b0, b};
                        r.value = up[63:32];
                    end
                    iamd_pkg::F3_DIV: begin
                        if (b == 0) r.value = '1;
                        else begin
                            q = (a[31] ? -a : a) / (b[31] ? -b : b);
                            r.value = (a[31] ^ b[31]) ? -q : q;
                        end
                    end
                    iamd_pkg::F3_DIVU: r.value = (b == 0) ? '1 : a / b;
                    iamd_pkg::F3_REM: begin
                        if (b == 0) r.value = a;
                        else begin
                            q = (a[31] ? -a : a) % (b[31] ? -b : b);
                            r.value = a[31] ? -q : q;
                        end
                    end
                    default: r.value = (b == 0) ? a : a % b;
                endcase
            end else bad = 1;
        end else if (opc == iamd_pkg::OP_IMM) begin
            case (f3)
                iamd_pkg::F3_SLL: if (f7 == iamd_pkg::F7_BASE) r.value = a << sh; else bad = 1;
                iamd_pkg::F3_SR: begin
                    if (f7 == iamd_pkg::F7_BASE) r.value = a >> sh;
                    else if (f7 == iamd_pkg::F7_ALT) r.value = $unsigned($signed(a) >>> sh);
                    else bad = 1;
                end
                iamd_pkg::F3_ADD:  r.value = a + imm;
                iamd_pkg::F3_SLT:  r.value = {31'b0, $signed(a) < $signed(imm)};
                iamd_pkg::F3_SLTU: r.value = {31'b0, a < imm};
                iamd_pkg::F3_XOR:  r.value = a ^ imm;
                iamd_pkg::F3_OR:   r.value = a | imm;
                default:           r.value = a & imm;
            endcase
        end else bad = 1;
        r.rd = ins[11:7];
        r.illegal = bad;
        r.wrote = 0;
        if (bad) r.value = '0;
        else if (r.rd != 0 && r.rd < iamd_pkg::NUM_REGS) begin
            shadow_regs[r.rd] = r.value;
            r.wrote = 1;
        end
        return r;
    endfunction

    function automatic logic [31:0] enc_reg(logic [6:0] f7, logic [2:0] f3,
                                            logic [4:0] rd, logic [4:0] rs1,
                                            logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, iamd_pkg::OP_REG};
    endfunction

    function automatic logic [31:0] enc_imm(logic [11:0] imm, logic [2:0] f3,
                                            logic [4:0] rd, logic [4:0] rs1);
        return {imm, rs1, f3, rd, iamd_pkg::OP_IMM};
    endfunction

    // mostly legal instructions with random fields, some noise
    function automatic logic [31:0] random_instr();
        int pick;
        logic [2:0] f3;
        pick = $urandom_range(0, 99);
        f3 = 3'($urandom_range(0, 7));
        if (pick < 40)
            return enc_reg($urandom_range(0, 1) ? iamd_pkg::F7_MULDIV :
                           (($urandom_range(0, 1) &&
                             (f3 == iamd_pkg::F3_ADD || f3 == iamd_pkg::F3_SR))
                            ? iamd_pkg::F7_ALT : iamd_pkg::F7_BASE),
                           f3, 5'($urandom), 5'($urandom), 5'($urandom));
        else if (pick < 75) begin
            // seed registers with wide values through imm ops
            if (f3 == iamd_pkg::F3_SLL)
                return {iamd_pkg::F7_BASE, 5'($urandom), 5'($urandom), f3,
                        5'($urandom), iamd_pkg::OP_IMM};
            if (f3 == iamd_pkg::F3_SR)
                return {$urandom_range(0, 1) ? iamd_pkg::F7_ALT : iamd_pkg::F7_BASE,
                        5'($urandom), 5'($urandom), f3, 5'($urandom), iamd_pkg::OP_IMM};
            return enc_imm(12'($urandom), f3, 5'($urandom), 5'($urandom));
        end else if (pick < 88)
            // lui-free way to get big values: xori with a random sign-extended immediate
            return enc_imm(12'($urandom), iamd_pkg::F3_XOR, 5'($urandom), 5'($urandom));
        else if (pick < 95)
            return {7'($urandom), 25'($urandom)} & 32'hFFFF_FFFF | 32'h33;
        else
            return $urandom;
    endfunction

    // driver: one item in flight on the input channel
    always @(posedge aclk) begin
        logic [31:0] next_ins;
        if (!aresetn) begin
            s_valid <= 0;
            s_instruction <= '0;
            for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) n_sent <= n_sent + 1;
            if (pending_instr.size() != 0 && !hold_sender &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                next_ins = pending_instr.pop_front();
                s_instruction <= next_ins;
                staged.push_back(execute(next_ins));
                s_valid <= 1;
            end else s_valid <= 0;
        end
    end

    // expectation recorded at the accepting edge, predicted at drive time
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(staged.pop_front());
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        exec_result_t exp_r;
        if (!aresetn) m_ready <= 0;
        else begin
            if (m_valid && m_ready) begin
                n_checked <= n_checked + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: rd %0d value %h",
                             $realtime, m_dest_index, m_write_value);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_dest_index !== exp_r.rd || m_write_value !== exp_r.value ||
                        m_wrote !== exp_r.wrote || m_illegal !== exp_r.illegal) begin
                        $display("%0t: mismatch expected rd %0d val %h wr %b ill %b,",
                                 $realtime, exp_r.rd, exp_r.value, exp_r.wrote,
                                 exp_r.illegal);
                        $display("    got rd %0d val %h wr %b ill %b",
                                 m_dest_index, m_write_value, m_wrote, m_illegal);
                        errors++;
                    end
                    if (exp_r.illegal) n_illegal++;
                end
            end
            m_ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic wait_drained();
        while (pending_instr.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [31:0] dir [$];
        aresetn = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, every op, illegal codes, rd zero, div corners
        dir.push_back(enc_imm(12'h7FF, iamd_pkg::F3_ADD, 5'd1, 5'd0));  // r1 = 2047
        dir.push_back(enc_imm(12'h800, iamd_pkg::F3_ADD, 5'd2, 5'd0));  // r2 = -2048
        dir.push_back(enc_imm(12'hFFF, iamd_pkg::F3_ADD, 5'd3, 5'd0));  // r3 = -1
        dir.push_back({iamd_pkg::F7_BASE, 5'd31, 5'd3, iamd_pkg::F3_SLL, 5'd4,
                       iamd_pkg::OP_IMM});                               // r4 = 0x80000000
        dir.push_back(enc_imm(12'hFFF, iamd_pkg::F3_XOR, 5'd31, 5'd4)); // r31 = 0x7fffffff
        dir.push_back(enc_reg(iamd_pkg::F7_MULDIV, iamd_pkg::F3_DIV, 5'd5, 5'd4,
                              5'd3));                                    // overflow div
        dir.push_back(enc_reg(iamd_pkg::F7_MULDIV, iamd_pkg::F3_REM, 5'd6, 5'd4,
                              5'd3));                                    // overflow rem
        for (int f = 0; f < 8; f++) begin
            dir.push_back(enc_reg(iamd_pkg::F7_MULDIV, f[2:0], 5'd7, 5'd2, 5'd0)); // by zero
            dir.push_back(enc_reg(iamd_pkg::F7_BASE, f[2:0], 5'd8, 5'd31, 5'd2));
        end
        dir.push_back(enc_reg(iamd_pkg::F7_ALT, iamd_pkg::F3_ADD, 5'd9, 5'd4, 5'd1));
        dir.push_back({iamd_pkg::F7_ALT, 5'd31, 5'd4, iamd_pkg::F3_SR, 5'd10,
                       iamd_pkg::OP_IMM});
        dir.push_back(enc_reg(iamd_pkg::F7_ALT, iamd_pkg::F3_XOR, 5'd11, 5'd1,
                              5'd2));                                    // illegal funct7
        dir.push_back({iamd_pkg::F7_ALT, 5'd1, 5'd1, iamd_pkg::F3_SLL, 5'd12,
                       iamd_pkg::OP_IMM});                               // illegal slli
        dir.push_back(32'hFFFF_FFFF);                                    // illegal opcode
        dir.push_back(enc_reg(iamd_pkg::F7_MULDIV, iamd_pkg::F3_MULH, 5'd0, 5'd31,
                              5'd31));                                   // rd zero
        foreach (dir[i]) pending_instr.push_back(dir[i]);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 19 : (phase == 1) ? 50 : 0;
            recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 19 : 0;
            for (int i = 0; i < 350; i++) pending_instr.push_back(random_instr());
            if (phase == 1) begin
                // sender holds off until the block has drained
                while (pending_instr.size() > 175) @(posedge aclk);
                hold_sender = 1;
                while (s_valid || expected_results.size() != 0) @(posedge aclk);
                hold_sender = 0;
            end
            wait_drained();
        end
        repeat (100) @(posedge aclk);
        $display("covered %0d instructions sent, %0d results checked (%0d illegal)",
                 n_sent, n_checked, n_illegal);
        $display("across three idle mixes and one full drain");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: integer_alu_with_muldiv.f
rtl/core/iamd_pkg.sv
rtl/core/integer_alu_with_muldiv.sv
test/testbench.sv
